FILE: hw/rtl/dense_matrix_multiply_defines.svh
// Assertion macros for the RTL files; the top-level module uses them.
`ifndef DENSE_MATRIX_MULTIPLY_DEFINES_SVH
`define DENSE_MATRIX_MULTIPLY_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define DMM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define DMM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/dmm_pkg.sv
package dmm_pkg;

    localparam int MAX_ROWS  = 8;
    localparam int MAX_COLS  = 8;
    localparam int MAX_INNER = 8;
    localparam int DEPTH     = 64;
    localparam int AW        = 6;
    localparam int IW        = 3;
    localparam int DIMW      = 4;
    localparam int FW        = 16;
    localparam int SW        = 32;
    localparam int DRAIN_LEN = MAX_COLS + 4;

    localparam logic [DIMW-1:0] MAX_ROWS_D  = DIMW'(MAX_ROWS);
    localparam logic [DIMW-1:0] MAX_COLS_D  = DIMW'(MAX_COLS);
    localparam logic [DIMW-1:0] MAX_INNER_D = DIMW'(MAX_INNER);

    localparam logic signed [SW-1:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [SW-1:0] SAT_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        OP_LOAD_A = 2'd0,
        OP_LOAD_B = 2'd1,
        OP_LOAD_C = 2'd2,
        OP_RUN    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        REG_ROWS  = 2'd0,
        REG_COLS  = 2'd1,
        REG_INNER = 2'd2,
        REG_ACCUM = 2'd3
    } cfg_idx_t;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_BSWEEP = 6'b000010,
        S_CINIT  = 6'b000100,
        S_AFEED  = 6'b001000,
        S_DRAIN  = 6'b010000,
        S_EMIT   = 6'b100000
    } state_t;

    // One word travelling down the cell chain.
    typedef struct packed {
        logic                 vld;
        logic [IW-1:0]        t;
        logic signed [FW-1:0] a;
    } link_t;

    function automatic logic [DIMW-1:0] clamp_dim(logic [DIMW-1:0] v,
                                                  logic [DIMW-1:0] maxv);
        logic [DIMW-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = DIMW'(1);
        end
        else if (v > maxv)
        begin
            r = maxv;
        end
        return r;
    endfunction

    function automatic logic signed [SW-1:0] sat_add(logic signed [SW-1:0] x,
                                                     logic signed [SW-1:0] y);
        logic signed [SW:0] s;
        logic signed [SW-1:0] r;
        s = {x[SW-1], x} + {y[SW-1], y};
        if (s[SW] != s[SW-1])
        begin
            r = s[SW] ? SAT_MIN : SAT_MAX;
        end
        else
        begin
            r = s[SW-1:0];
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/dmm_store.sv
module dmm_store (
    input  logic                              clk,
    input  logic                              a_we,
    input  logic [dmm_pkg::AW-1:0]            a_waddr,
    input  logic signed [dmm_pkg::FW-1:0]     a_wdata,
    input  logic [dmm_pkg::AW-1:0]            a_raddr,
    output logic signed [dmm_pkg::FW-1:0]     a_rdata,
    input  logic                              b_we,
    input  logic [dmm_pkg::AW-1:0]            b_waddr,
    input  logic signed [dmm_pkg::FW-1:0]     b_wdata,
    input  logic [dmm_pkg::AW-1:0]            b_raddr,
    output logic signed [dmm_pkg::FW-1:0]     b_rdata,
    input  logic                              c_we,
    input  logic [dmm_pkg::AW-1:0]            c_waddr,
    input  logic signed [dmm_pkg::SW-1:0]     c_wdata,
    input  logic [dmm_pkg::AW-1:0]            c_raddr,
    output logic signed [dmm_pkg::SW-1:0]     c_rdata
);

    logic signed [dmm_pkg::FW-1:0] a_mem [dmm_pkg::DEPTH];
    logic signed [dmm_pkg::FW-1:0] b_mem [dmm_pkg::DEPTH];
    logic signed [dmm_pkg::SW-1:0] c_mem [dmm_pkg::DEPTH];

    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            a_mem[a_waddr] <= a_wdata;
        end
        a_rdata <= a_mem[a_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (b_we)
        begin
            b_mem[b_waddr] <= b_wdata;
        end
        b_rdata <= b_mem[b_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (c_we)
        begin
            c_mem[c_waddr] <= c_wdata;
        end
        c_rdata <= c_mem[c_raddr];
    end

endmodule

FILE: hw/rtl/dmm_cell.sv
// One column cell: holds a column of B and the running sum of one C entry.
module dmm_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          b_we,
    input  logic [dmm_pkg::IW-1:0]        b_idx,
    input  logic signed [dmm_pkg::FW-1:0] b_data,
    input  logic                          init_we,
    input  logic signed [dmm_pkg::SW-1:0] init_data,
    input  dmm_pkg::link_t                link_in,
    output dmm_pkg::link_t                link_out,
    output logic signed [dmm_pkg::SW-1:0] acc
);

    logic signed [dmm_pkg::FW-1:0] b_reg [dmm_pkg::MAX_INNER];
    dmm_pkg::link_t                link_reg;
    logic signed [dmm_pkg::FW-1:0] b_sel;
    logic signed [dmm_pkg::SW-1:0] prod_reg;
    logic signed [dmm_pkg::SW-1:0] prod_next;
    logic                          prod_vld_reg;
    logic signed [dmm_pkg::SW-1:0] acc_reg;
    logic signed [dmm_pkg::SW-1:0] acc_next;

    always_ff @(posedge clk)
    begin
        if (b_we)
        begin
            b_reg[b_idx] <= b_data;
        end
    end

    assign b_sel     = b_reg[link_reg.t];
    assign prod_next = link_reg.a * b_sel;

    always_comb
    begin
        acc_next = acc_reg;
        if (init_we)
        begin
            acc_next = init_data;
        end
        else if (prod_vld_reg)
        begin
            acc_next = dmm_pkg::sat_add(acc_reg, prod_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg     <= '0;
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            link_reg     <= link_in;
            prod_vld_reg <= link_reg.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign link_out = link_reg;
    assign acc      = acc_reg;

endmodule

FILE: hw/rtl/dense_matrix_multiply.sv
// Channel  | Dir | Width        | Contents
// s_axis   | in  | 56 + user 2  | tdata: element_index, factor_value, sum_value; tuser: operation
// m_axis   | out | 40 + last 1  | tdata: product_value, out_row, out_col; tlast: last_entry
// cfg      | in  | idx 2, dat 4 | register writes: rows_m, cols_n, inner_k, accumulate_mode
//
// A load word is accepted whenever the block is idle.
// A compute word runs a B sweep into the column cells, then per row a C
// preload, the A feed down the cell chain, a drain of the chain, and the
// emit of the row's results.
// The single read port of each store sets the feed and preload lengths.
// Emit cycles stretch while the output register is held by m_axis_tready low.
// Reset clears control state and the configuration; the stores are not cleared.
`include "dense_matrix_multiply_defines.svh"

module dense_matrix_multiply (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [5:0] element_index, [21:6] factor_value, [53:22] sum_value, [55:54] zero
    input  logic [55:0] s_axis_tdata,
    // [1:0] operation
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] product_value, [34:32] out_row, [37:35] out_col, [39:38] zero
    output logic [39:0] m_axis_tdata,
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [3:0]  cfg_data
);

    localparam int AW   = dmm_pkg::AW;
    localparam int IW   = dmm_pkg::IW;
    localparam int DIMW = dmm_pkg::DIMW;
    localparam int FW   = dmm_pkg::FW;
    localparam int SW   = dmm_pkg::SW;
    localparam int NC   = dmm_pkg::MAX_COLS;

    // Configuration registers.
    logic [DIMW-1:0] rows_m_reg;
    logic [DIMW-1:0] cols_n_reg;
    logic [DIMW-1:0] inner_k_reg;
    logic            accum_reg;
    logic [DIMW-1:0] m_eff;
    logic [DIMW-1:0] n_eff;
    logic [DIMW-1:0] k_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_m_reg  <= DIMW'(1);
            cols_n_reg  <= DIMW'(1);
            inner_k_reg <= DIMW'(1);
            accum_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (dmm_pkg::cfg_idx_t'(cfg_index))
                dmm_pkg::REG_ROWS:  rows_m_reg  <= cfg_data;
                dmm_pkg::REG_COLS:  cols_n_reg  <= cfg_data;
                dmm_pkg::REG_INNER: inner_k_reg <= cfg_data;
                dmm_pkg::REG_ACCUM: accum_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign m_eff = dmm_pkg::clamp_dim(rows_m_reg, dmm_pkg::MAX_ROWS_D);
    assign n_eff = dmm_pkg::clamp_dim(cols_n_reg, dmm_pkg::MAX_COLS_D);
    assign k_eff = dmm_pkg::clamp_dim(inner_k_reg, dmm_pkg::MAX_INNER_D);

    // Input word fields.
    dmm_pkg::op_t                in_op;
    logic [AW-1:0]               in_idx;
    logic signed [FW-1:0]        in_factor;
    logic signed [SW-1:0]        in_sum;
    logic                        in_acc;

    assign in_op     = dmm_pkg::op_t'(s_axis_tuser);
    assign in_idx    = s_axis_tdata[5:0];
    assign in_factor = s_axis_tdata[21:6];
    assign in_sum    = s_axis_tdata[53:22];
    assign in_acc    = s_axis_tvalid && s_axis_tready;

    // Sequencer state.
    dmm_pkg::state_t state_reg, state_next;
    logic [IW-1:0]   i_reg, i_next;
    logic [IW-1:0]   j_reg, j_next;
    logic [IW-1:0]   t_reg, t_next;
    logic [AW-1:0]   baddr_reg, baddr_next;
    logic [AW-1:0]   abase_reg, abase_next;
    logic [AW-1:0]   cbase_reg, cbase_next;
    logic [DIMW-1:0] drain_reg, drain_next;

    // Read tags, aligned with the registered store outputs.
    logic          btag_vld_reg, btag_vld_next;
    logic [IW-1:0] btag_t_reg;
    logic [IW-1:0] btag_j_reg;
    logic          ctag_vld_reg, ctag_vld_next;
    logic [IW-1:0] ctag_j_reg;
    logic          atag_vld_reg, atag_vld_next;
    logic [IW-1:0] atag_t_reg;

    // Output register.
    logic                 out_vld_reg, out_vld_next;
    logic signed [SW-1:0] out_val_reg;
    logic [IW-1:0]        out_row_reg;
    logic [IW-1:0]        out_col_reg;
    logic                 out_last_reg;
    logic                 emit_fire;
    logic                 last_col;
    logic                 last_row;
    logic                 last_t;

    // Store signals.
    logic [AW-1:0]        a_raddr, b_raddr, c_raddr, c_waddr;
    logic signed [FW-1:0] a_rdata, b_rdata;
    logic signed [SW-1:0] c_rdata, c_wdata;
    logic                 c_we;
    logic signed [SW-1:0] acc_sel;

    assign s_axis_tready = (state_reg == dmm_pkg::S_IDLE);

    assign last_col = ({1'b0, j_reg} == n_eff - DIMW'(1));
    assign last_row = ({1'b0, i_reg} == m_eff - DIMW'(1));
    assign last_t   = ({1'b0, t_reg} == k_eff - DIMW'(1));
    assign emit_fire = (state_reg == dmm_pkg::S_EMIT) && (!out_vld_reg || m_axis_tready);

    assign a_raddr = abase_reg + AW'(t_reg);
    assign b_raddr = baddr_reg;
    assign c_raddr = cbase_reg + AW'(j_reg);

    always_comb
    begin
        state_next    = state_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        t_next        = t_reg;
        baddr_next    = baddr_reg;
        abase_next    = abase_reg;
        cbase_next    = cbase_reg;
        drain_next    = drain_reg;
        btag_vld_next = 1'b0;
        ctag_vld_next = 1'b0;
        atag_vld_next = 1'b0;
        unique case (state_reg)
            dmm_pkg::S_IDLE:
            begin
                if (in_acc && in_op == dmm_pkg::OP_RUN)
                begin
                    state_next = dmm_pkg::S_BSWEEP;
                    i_next     = '0;
                    j_next     = '0;
                    t_next     = '0;
                    baddr_next = '0;
                    abase_next = '0;
                    cbase_next = '0;
                end
            end
            dmm_pkg::S_BSWEEP:
            begin
                // B is row-major, so the sweep walks the store in address order.
                btag_vld_next = 1'b1;
                baddr_next    = baddr_reg + AW'(1);
                if (last_col)
                begin
                    j_next = '0;
                    if (last_t)
                    begin
                        t_next     = '0;
                        state_next = dmm_pkg::S_CINIT;
                    end
                    else
                    begin
                        t_next = t_reg + IW'(1);
                    end
                end
                else
                begin
                    j_next = j_reg + IW'(1);
                end
            end
            dmm_pkg::S_CINIT:
            begin
                ctag_vld_next = 1'b1;
                if (last_col)
                begin
                    j_next     = '0;
                    state_next = dmm_pkg::S_AFEED;
                end
                else
                begin
                    j_next = j_reg + IW'(1);
                end
            end
            dmm_pkg::S_AFEED:
            begin
                atag_vld_next = 1'b1;
                if (last_t)
                begin
                    t_next     = '0;
                    drain_next = '0;
                    state_next = dmm_pkg::S_DRAIN;
                end
                else
                begin
                    t_next = t_reg + IW'(1);
                end
            end
            dmm_pkg::S_DRAIN:
            begin
                drain_next = drain_reg + DIMW'(1);
                if (drain_reg == DIMW'(dmm_pkg::DRAIN_LEN - 1))
                begin
                    state_next = dmm_pkg::S_EMIT;
                end
            end
            dmm_pkg::S_EMIT:
            begin
                if (emit_fire)
                begin
                    if (last_col)
                    begin
                        j_next = '0;
                        if (last_row)
                        begin
                            state_next = dmm_pkg::S_IDLE;
                        end
                        else
                        begin
                            i_next     = i_reg + IW'(1);
                            abase_next = abase_reg + AW'(k_eff);
                            cbase_next = cbase_reg + AW'(n_eff);
                            state_next = dmm_pkg::S_CINIT;
                        end
                    end
                    else
                    begin
                        j_next = j_reg + IW'(1);
                    end
                end
            end
            default:
            begin
                state_next = dmm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= dmm_pkg::S_IDLE;
            i_reg        <= '0;
            j_reg        <= '0;
            t_reg        <= '0;
            baddr_reg    <= '0;
            abase_reg    <= '0;
            cbase_reg    <= '0;
            drain_reg    <= '0;
            btag_vld_reg <= 1'b0;
            ctag_vld_reg <= 1'b0;
            atag_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            t_reg        <= t_next;
            baddr_reg    <= baddr_next;
            abase_reg    <= abase_next;
            cbase_reg    <= cbase_next;
            drain_reg    <= drain_next;
            btag_vld_reg <= btag_vld_next;
            ctag_vld_reg <= ctag_vld_next;
            atag_vld_reg <= atag_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        btag_t_reg <= t_reg;
        btag_j_reg <= j_reg;
        ctag_j_reg <= j_reg;
        atag_t_reg <= t_reg;
    end

    // Loads write the stores directly; C is also written back during emit.
    assign c_we    = (in_acc && in_op == dmm_pkg::OP_LOAD_C) || emit_fire;
    assign c_waddr = emit_fire ? c_raddr : in_idx;
    assign c_wdata = emit_fire ? acc_sel : in_sum;

    dmm_store u_store (
        .clk     (clk),
        .a_we    (in_acc && in_op == dmm_pkg::OP_LOAD_A),
        .a_waddr (in_idx),
        .a_wdata (in_factor),
        .a_raddr (a_raddr),
        .a_rdata (a_rdata),
        .b_we    (in_acc && in_op == dmm_pkg::OP_LOAD_B),
        .b_waddr (in_idx),
        .b_wdata (in_factor),
        .b_raddr (b_raddr),
        .b_rdata (b_rdata),
        .c_we    (c_we),
        .c_waddr (c_waddr),
        .c_wdata (c_wdata),
        .c_raddr (c_raddr),
        .c_rdata (c_rdata)
    );

    // The cell chain: A entries enter cell 0 and step one cell per cycle.
    dmm_pkg::link_t       link [NC+1];
    logic signed [SW-1:0] cell_acc [NC];
    logic signed [SW-1:0] init_val;

    assign link[0].vld = atag_vld_reg;
    assign link[0].t   = atag_t_reg;
    assign link[0].a   = a_rdata;
    assign init_val    = accum_reg ? c_rdata : '0;

    for (genvar g = 0; g < NC; g++)
    begin : g_cell
        dmm_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .b_we      (btag_vld_reg && btag_j_reg == IW'(g)),
            .b_idx     (btag_t_reg),
            .b_data    (b_rdata),
            .init_we   (ctag_vld_reg && ctag_j_reg == IW'(g)),
            .init_data (init_val),
            .link_in   (link[g]),
            .link_out  (link[g+1]),
            .acc       (cell_acc[g])
        );
    end

    assign acc_sel = cell_acc[j_reg];

    // Output register: refilled on the same edge that hands the old word over.
    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (emit_fire)
        begin
            out_vld_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            out_val_reg  <= acc_sel;
            out_row_reg  <= i_reg;
            out_col_reg  <= j_reg;
            out_last_reg <= last_col && last_row;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {2'b00, out_col_reg, out_row_reg, out_val_reg};

    // The marked word is the final column of the result.
    `DMM_ASSERT_IMP(a_last_col, m_axis_tvalid && m_axis_tlast, {1'b0, out_col_reg} == n_eff - DIMW'(1), "last word not in final column")
    // A compute word always starts with the B sweep.
    `DMM_ASSERT_NXT(a_run_start, in_acc && in_op == dmm_pkg::OP_RUN, state_reg == dmm_pkg::S_BSWEEP, "compute did not start B sweep")
    // Emit never selects a cell beyond the active columns.
    `DMM_ASSERT_IMP(a_emit_col, state_reg == dmm_pkg::S_EMIT, {1'b0, j_reg} < n_eff, "emit column out of range")
    // The chain is empty by the time results are read out.
    `DMM_ASSERT_IMP(a_chain_idle, state_reg == dmm_pkg::S_EMIT, !atag_vld_reg && !link[NC].vld, "chain busy during emit")

endmodule

FILE: tb/sv/dense_matrix_multiply_check.sv
`timescale 1ns / 1ps

module dense_matrix_multiply_check (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,
    input  logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [3:0]  cfg_data,
    output int          errors,
    output int          pending
);

    typedef struct {
        logic signed [dmm_pkg::SW-1:0] value;
        logic [dmm_pkg::IW-1:0]        row;
        logic [dmm_pkg::IW-1:0]        col;
        logic                          last;
    } c_entry_t;

    c_entry_t                      c_awaited[$];
    logic signed [dmm_pkg::FW-1:0] a_store [dmm_pkg::DEPTH];
    logic signed [dmm_pkg::FW-1:0] b_store [dmm_pkg::DEPTH];
    logic signed [dmm_pkg::SW-1:0] c_store [dmm_pkg::DEPTH];
    logic [dmm_pkg::DIMW-1:0]      rows_r;
    logic [dmm_pkg::DIMW-1:0]      cols_r;
    logic [dmm_pkg::DIMW-1:0]      inner_r;
    logic                          accum_r;

    function automatic int eff_dim(logic [dmm_pkg::DIMW-1:0] v, int maxv);
        int r;
        r = int'(v);
        if (r < 1)
        begin
            r = 1;
        end
        else if (r > maxv)
        begin
            r = maxv;
        end
        return r;
    endfunction

    // Forms every entry of C in row-major order and queues it.
    task automatic predict_product();
        int m;
        int n;
        int k;
        longint acc;
        int caddr;
        c_entry_t e;
        m = eff_dim(rows_r, dmm_pkg::MAX_ROWS);
        n = eff_dim(cols_r, dmm_pkg::MAX_COLS);
        k = eff_dim(inner_r, dmm_pkg::MAX_INNER);
        for (int i = 0; i < m; i++)
        begin
            for (int j = 0; j < n; j++)
            begin
                caddr = (i * n + j) % dmm_pkg::DEPTH;
                acc = accum_r ? longint'(c_store[caddr]) : 0;
                for (int t = 0; t < k; t++)
                begin
                    acc += longint'(a_store[(i * k + t) % dmm_pkg::DEPTH])
                         * longint'(b_store[(t * n + j) % dmm_pkg::DEPTH]);
                    // The running sum saturates after every addition.
                    if (acc > longint'(dmm_pkg::SAT_MAX))
                    begin
                        acc = longint'(dmm_pkg::SAT_MAX);
                    end
                    else if (acc < longint'(dmm_pkg::SAT_MIN))
                    begin
                        acc = longint'(dmm_pkg::SAT_MIN);
                    end
                end
                c_store[caddr] = dmm_pkg::SW'(acc);
                e.value = dmm_pkg::SW'(acc);
                e.row = dmm_pkg::IW'(i);
                e.col = dmm_pkg::IW'(j);
                e.last = (i == m - 1) && (j == n - 1);
                c_awaited.push_back(e);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        c_entry_t e;
        if (!rst_n)
        begin
            rows_r <= dmm_pkg::DIMW'(1);
            cols_r <= dmm_pkg::DIMW'(1);
            inner_r <= dmm_pkg::DIMW'(1);
            accum_r <= 1'b0;
            errors = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (dmm_pkg::cfg_idx_t'(cfg_index))
                    dmm_pkg::REG_ROWS:  rows_r <= cfg_data;
                    dmm_pkg::REG_COLS:  cols_r <= cfg_data;
                    dmm_pkg::REG_INNER: inner_r <= cfg_data;
                    dmm_pkg::REG_ACCUM: accum_r <= cfg_data[0];
                    default:   ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                case (dmm_pkg::op_t'(s_axis_tuser))
                    dmm_pkg::OP_LOAD_A: a_store[s_axis_tdata[5:0]] = s_axis_tdata[21:6];
                    dmm_pkg::OP_LOAD_B: b_store[s_axis_tdata[5:0]] = s_axis_tdata[21:6];
                    dmm_pkg::OP_LOAD_C: c_store[s_axis_tdata[5:0]] = s_axis_tdata[53:22];
                    default:   predict_product();
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (c_awaited.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected word value=%h row=%0d col=%0d last=%b",
                             $time, m_axis_tdata[31:0], m_axis_tdata[34:32],
                             m_axis_tdata[37:35], m_axis_tlast);
                end
                else
                begin
                    e = c_awaited.pop_front();
                    if (m_axis_tdata[31:0] !== e.value || m_axis_tdata[34:32] !== e.row
                        || m_axis_tdata[37:35] !== e.col || m_axis_tlast !== e.last)
                    begin
                        errors++;
                        $display("%0t: mismatch expected value=%h row=%0d col=%0d last=%b",
                                 $time, e.value, e.row, e.col, e.last);
                        $display("%0t:          actual   value=%h row=%0d col=%0d last=%b",
                                 $time, m_axis_tdata[31:0], m_axis_tdata[34:32],
                                 m_axis_tdata[37:35], m_axis_tlast);
                    end
                end
            end
            pending = c_awaited.size();
        end
    end

endmodule

FILE: tb/sv/dense_matrix_multiply_test.sv
`timescale 1ns / 1ps

module dense_matrix_multiply_test;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // [5:0] element_index, [21:6] factor_value, [53:22] sum_value, [55:54] zero
    logic [55:0] s_axis_tdata;
    // [1:0] operation
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // [31:0] product_value, [34:32] out_row, [37:35] out_col, [39:38] zero
    logic [39:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [3:0]  cfg_data;
    int          errors;
    int          pending;

    // Sender burst bookkeeping and a count of delivered result words.
    int burst_left;
    int words_out;

    dense_matrix_multiply uut (.*);

    dense_matrix_multiply_check checker_i (.*);

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
        begin
            words_out++;
        end
    end

    // Offers one word. Before it, the sender sits idle for a random gap
    // when its current burst has run out. The word is held until accepted,
    // and tvalid stays high so that the next word of a burst follows at once.
    task automatic offer_word(dmm_pkg::op_t op, logic [5:0] idx, logic [15:0] f,
                              logic [31:0] s);
        if (burst_left == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {2'b00, s, f, idx};
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // Waits until every expected result has arrived, then lets the block
    // finish any internal write-back before the configuration changes.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (40) @(negedge clk);
    endtask

    task automatic write_reg(dmm_pkg::cfg_idx_t idx, logic [3:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Factor values lean on the extremes so that saturation is reached often.
    function automatic logic [15:0] pick_factor();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_sum();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [3:0] pick_dim();
        case ($urandom_range(0, 5))
            0: return 4'd0;
            1: return 4'd15;
            2: return 4'd8;
            3: return 4'd1;
            default: return 4'($urandom_range(0, 15));
        endcase
    endfunction

    // The receiver mixes random stalls, fully ready stretches and rare long
    // hold-offs. One long hold-off is forced once results are flowing, so
    // that the block backs up and refuses new words.
    initial
    begin
        bit forced;
        int mode;
        forced = 0;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            mode = $urandom_range(0, 29);
            if (!forced && words_out >= 100)
            begin
                forced = 1;
                mode = 0;
            end
            if (mode == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(300, 600)) @(negedge clk);
            end
            else if (mode < 10)
            begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(5, 40)) @(negedge clk);
            end
            else
            begin
                repeat ($urandom_range(5, 40))
                begin
                    m_axis_tready <= ($urandom_range(0, 2) != 0);
                    @(negedge clk);
                end
            end
        end
    end

    initial
    begin
        #4ms;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        int items;
        int run_len;
        int op_pick;
        burst_left = 0;
        words_out = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = dmm_pkg::OP_LOAD_A;
        cfg_we = 1'b0;
        cfg_index = dmm_pkg::REG_ROWS;
        cfg_data = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part at the reset size of one by one by one.
        // A plain product of the two most negative factors.
        offer_word(dmm_pkg::OP_LOAD_A, 6'd0, 16'h8000, 32'hFFFF_FFFF);
        offer_word(dmm_pkg::OP_LOAD_B, 6'd0, 16'h8000, 32'h0);
        offer_word(dmm_pkg::OP_LOAD_C, 6'd0, 16'hFFFF, 32'h7FFF_FFFF);
        offer_word(dmm_pkg::OP_RUN, 6'd63, 16'hFFFF, 32'hFFFF_FFFF);
        // Loads beyond the current size must not disturb the result.
        offer_word(dmm_pkg::OP_LOAD_A, 6'd63, 16'h7FFF, 32'h0);
        offer_word(dmm_pkg::OP_LOAD_B, 6'd63, 16'h7FFF, 32'h0);
        offer_word(dmm_pkg::OP_LOAD_C, 6'd63, 16'h0, 32'h8000_0000);
        offer_word(dmm_pkg::OP_LOAD_C, 6'd0, 16'h0, 32'h7FFF_FFFF);
        drain_results();
        // Accumulating onto the largest sum saturates upward.
        write_reg(dmm_pkg::REG_ACCUM, 4'd1);
        offer_word(dmm_pkg::OP_RUN, 6'd0, 16'h0, 32'h0);
        offer_word(dmm_pkg::OP_LOAD_A, 6'd0, 16'h7FFF, 32'h0);
        offer_word(dmm_pkg::OP_LOAD_C, 6'd0, 16'h0, 32'h8000_0000);
        offer_word(dmm_pkg::OP_RUN, 6'd0, 16'h0, 32'h0);
        // Accumulating a negative product onto the smallest sum saturates downward.
        offer_word(dmm_pkg::OP_LOAD_A, 6'd0, 16'h8000, 32'h0);
        offer_word(dmm_pkg::OP_LOAD_B, 6'd0, 16'h7FFF, 32'h0);
        offer_word(dmm_pkg::OP_LOAD_C, 6'd0, 16'h0, 32'h8000_0000);
        offer_word(dmm_pkg::OP_RUN, 6'd0, 16'h0, 32'h0);
        drain_results();

        // Fill every store entry so that any later size reads written data.
        write_reg(dmm_pkg::REG_ACCUM, 4'd0);
        for (int a = 0; a < dmm_pkg::DEPTH; a++)
        begin
            offer_word(dmm_pkg::OP_LOAD_A, 6'(a), pick_factor(), $urandom);
            offer_word(dmm_pkg::OP_LOAD_B, 6'(a), pick_factor(), $urandom);
            offer_word(dmm_pkg::OP_LOAD_C, 6'(a), 16'($urandom), pick_sum());
        end

        // Full size with all factors at the negative extreme: every sum
        // of eight products overflows.
        drain_results();
        write_reg(dmm_pkg::REG_ROWS, 4'd8);
        write_reg(dmm_pkg::REG_COLS, 4'd8);
        write_reg(dmm_pkg::REG_INNER, 4'd8);
        for (int a = 0; a < dmm_pkg::DEPTH; a++)
        begin
            offer_word(dmm_pkg::OP_LOAD_A, 6'(a), 16'h8000, 32'h0);
            offer_word(dmm_pkg::OP_LOAD_B, 6'(a), 16'h8000, 32'h0);
        end
        offer_word(dmm_pkg::OP_RUN, 6'd0, 16'h0, 32'h0);

        // Random phases: a new setting, then loads with computes among them.
        items = 0;
        while (items < 200)
        begin
            drain_results();
            write_reg(dmm_pkg::REG_ROWS, pick_dim());
            write_reg(dmm_pkg::REG_COLS, pick_dim());
            write_reg(dmm_pkg::REG_INNER, pick_dim());
            write_reg(dmm_pkg::REG_ACCUM, 4'($urandom_range(0, 15)));
            run_len = $urandom_range(4, 24);
            for (int w = 0; w < run_len; w++)
            begin
                op_pick = $urandom_range(0, 7);
                if (op_pick == 0)
                begin
                    offer_word(dmm_pkg::OP_RUN, 6'($urandom), 16'($urandom), $urandom);
                end
                else
                begin
                    offer_word(dmm_pkg::op_t'($urandom_range(0, 2)), 6'($urandom),
                               pick_factor(), pick_sum());
                end
                items++;
            end
            offer_word(dmm_pkg::OP_RUN, 6'($urandom), 16'($urandom), $urandom);
            items++;
        end

        drain_results();
        repeat (100) @(negedge clk);
        if (errors == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
